// ===== hw/rtl/scmpwm_pkg.sv =====
package scmpwm_pkg;

    localparam logic [15:0] RESET_WIDTH  = 16'd2000;
    localparam logic [15:0] PERIOD_RESET = 16'd39999;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_BYTE = 1'b1;

    localparam logic [7:0] CHAR_FRAME  = 8'h4D; // 'M'
    localparam logic [7:0] CHAR_COMMIT = 8'h3B; // ';'
    localparam logic [7:0] CHAR_QUERY  = 8'h3F; // '?'
    localparam logic [7:0] CHAR_FWD    = 8'h66; // 'f'
    localparam logic [7:0] CHAR_BACK   = 8'h62; // 'b'
    localparam logic [7:0] CHAR_LEFT   = 8'h6C; // 'l'
    localparam logic [7:0] CHAR_RIGHT  = 8'h72; // 'r'
    localparam logic [7:0] CHAR_HALT   = 8'h68; // 'h'

    localparam logic [3:0] MOTOR_FWD   = 4'b1010;
    localparam logic [3:0] MOTOR_BACK  = 4'b0101;
    localparam logic [3:0] MOTOR_LEFT  = 4'b1000;
    localparam logic [3:0] MOTOR_RIGHT = 4'b0010;
    localparam logic [3:0] MOTOR_HALT  = 4'b0000;

    localparam logic [7:0] REPLY_BYTE = 8'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_EMIT,
        ST_REPLY,
        ST_QUERY
    } state_t;

    typedef enum logic [1:0] {
        CLS_TICK,
        CLS_PLAIN,
        CLS_REPLY,
        CLS_QUERY
    } item_class_t;

    typedef struct packed {
        logic tick_step;
        logic tick_cmp;
        logic take_byte;
        logic query_start;
        logic emit;
        logic reply;
        logic query_beat;
    } cmd_t;

    typedef struct packed {
        item_class_t item_class;
        logic        out_free;
        logic        query_last;
    } stat_t;

endpackage

// ===== hw/rtl/scmpwm_ctrl.sv =====
module scmpwm_ctrl
    import scmpwm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    case (stat.item_class)
                        CLS_TICK:
                        begin
                            cmd.tick_step = 1'b1;
                            state_next    = ST_CMP;
                        end
                        CLS_QUERY:
                        begin
                            cmd.take_byte   = 1'b1;
                            cmd.query_start = 1'b1;
                            state_next      = ST_QUERY;
                        end
                        CLS_REPLY:
                        begin
                            cmd.take_byte = 1'b1;
                            state_next    = ST_REPLY;
                        end
                        default:
                        begin
                            cmd.take_byte = 1'b1;
                            state_next    = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_CMP:
            begin
                cmd.tick_cmp = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_REPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.reply  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_QUERY:
            begin
                if (stat.out_free)
                begin
                    cmd.query_beat = 1'b1;
                    if (stat.query_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // query beats only while the output stage can take them
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.query_beat |-> stat.out_free)
        else $error("query beat issued into a full output stage");

    // an item is taken only from idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take_byte || cmd.tick_step) |-> (state_reg == ST_IDLE && s_tvalid))
        else $error("item taken outside idle");

    // a tick always compares on the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick_step |=> cmd.tick_cmp)
        else $error("tick compare skipped");

endmodule

// ===== hw/rtl/scmpwm_dp.sv =====
module scmpwm_dp
    import scmpwm_pkg::*;
#(
    parameter int NUM_CHANNELS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    output logic [31:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  cmd_t        cmd,
    output stat_t       stat
);

    localparam int FRAME_LEN = 2 * NUM_CHANNELS;
    localparam int FIDX_W    = $clog2(FRAME_LEN + 1);
    localparam int CH_IW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int Q_W       = CH_IW + 1;
    localparam logic [Q_W-1:0]    Q_LAST    = Q_W'(FRAME_LEN - 1);
    localparam logic [FIDX_W-1:0] FIDX_END  = FIDX_W'(FRAME_LEN);

    logic [15:0]             period_reg, period_next;
    logic [15:0]             counter_reg, counter_next;
    logic [15:0]             active_reg  [NUM_CHANNELS];
    logic [15:0]             active_next [NUM_CHANNELS];
    logic [15:0]             pending_reg [NUM_CHANNELS];
    logic [15:0]             pending_next[NUM_CHANNELS];
    logic [15:0]             recv_reg    [NUM_CHANNELS];
    logic [15:0]             recv_next   [NUM_CHANNELS];
    logic                    pend_valid_reg, pend_valid_next;
    logic [7:0]              held_reg, held_next;
    logic                    frame_reg, frame_next;
    logic [FIDX_W-1:0]       fidx_reg, fidx_next;
    logic [NUM_CHANNELS-1:0] levels_reg, levels_next;
    logic [3:0]              motor_reg, motor_next;
    logic [Q_W-1:0]          qidx_reg, qidx_next;
    logic                    out_valid_reg, out_valid_next;
    logic [31:0]             out_data_reg, out_data_next;
    logic                    out_last_reg, out_last_next;

    logic [15:0] levels16;
    logic [15:0] query_word;
    logic [7:0]  query_byte;

    always_comb
    begin
        levels16 = '0;
        for (int i = 0; i < NUM_CHANNELS && i < 16; i++)
        begin
            levels16[i] = levels_reg[i];
        end
    end

    assign query_word = recv_reg[qidx_reg[CH_IW:1]];
    assign query_byte = qidx_reg[0] ? query_word[7:0] : query_word[15:8];

    always_comb
    begin
        if (s_tuser == KIND_TICK)
        begin
            stat.item_class = CLS_TICK;
        end
        else if (frame_reg)
        begin
            stat.item_class = CLS_PLAIN;
        end
        else if (s_tdata == CHAR_QUERY)
        begin
            stat.item_class = CLS_QUERY;
        end
        else if (s_tdata inside {CHAR_FWD, CHAR_BACK, CHAR_LEFT, CHAR_RIGHT, CHAR_HALT})
        begin
            stat.item_class = CLS_REPLY;
        end
        else
        begin
            stat.item_class = CLS_PLAIN;
        end
    end

    assign stat.out_free   = !out_valid_reg || m_tready;
    assign stat.query_last = (qidx_reg == Q_LAST);

    always_comb
    begin
        period_next     = period_reg;
        counter_next    = counter_reg;
        active_next     = active_reg;
        pending_next    = pending_reg;
        recv_next       = recv_reg;
        pend_valid_next = pend_valid_reg;
        held_next       = held_reg;
        frame_next      = frame_reg;
        fidx_next       = fidx_reg;
        levels_next     = levels_reg;
        motor_next      = motor_reg;
        qidx_next       = qidx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;

        if (cfg_valid)
        begin
            period_next = cfg_data;
        end

        if (cmd.tick_step)
        begin
            if (counter_reg >= period_reg)
            begin
                counter_next = '0;
                levels_next  = '1;
                if (pend_valid_reg)
                begin
                    active_next     = pending_reg;
                    pend_valid_next = 1'b0;
                end
            end
            else
            begin
                counter_next = counter_reg + 16'd1;
            end
        end

        if (cmd.tick_cmp)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                if (active_reg[i] == counter_reg)
                begin
                    levels_next[i] = 1'b0;
                end
            end
        end

        if (cmd.take_byte)
        begin
            if (frame_reg)
            begin
                if (fidx_reg < FIDX_END)
                begin
                    if (!fidx_reg[0])
                    begin
                        held_next = s_tdata;
                    end
                    else
                    begin
                        recv_next[fidx_reg[CH_IW:1]] = {held_reg, s_tdata};
                    end
                    fidx_next = fidx_reg + FIDX_W'(1);
                end
                else
                begin
                    frame_next = 1'b0;
                    fidx_next  = '0;
                    if (s_tdata == CHAR_COMMIT)
                    begin
                        pending_next    = recv_reg;
                        pend_valid_next = 1'b1;
                    end
                end
            end
            else
            begin
                case (s_tdata)
                    CHAR_FRAME:
                    begin
                        frame_next = 1'b1;
                        fidx_next  = '0;
                    end
                    CHAR_FWD:   motor_next = MOTOR_FWD;
                    CHAR_BACK:  motor_next = MOTOR_BACK;
                    CHAR_LEFT:  motor_next = MOTOR_LEFT;
                    CHAR_RIGHT: motor_next = MOTOR_RIGHT;
                    CHAR_HALT:  motor_next = MOTOR_HALT;
                    default:    motor_next = motor_reg;
                endcase
            end
        end

        if (cmd.query_start)
        begin
            qidx_next = '0;
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b1;
            out_data_next  = {3'b000, (cmd.reply ? REPLY_BYTE : 8'd0), cmd.reply,
                              motor_reg, levels16};
        end

        if (cmd.query_beat)
        begin
            out_valid_next = 1'b1;
            out_last_next  = stat.query_last;
            out_data_next  = {3'b000, query_byte, 1'b1, motor_reg, levels16};
            qidx_next      = qidx_reg + Q_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= PERIOD_RESET;
            counter_reg    <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                active_reg[i]  <= RESET_WIDTH;
                pending_reg[i] <= RESET_WIDTH;
                recv_reg[i]    <= RESET_WIDTH;
            end
            pend_valid_reg <= 1'b0;
            held_reg       <= '0;
            frame_reg      <= 1'b0;
            fidx_reg       <= '0;
            levels_reg     <= '1;
            motor_reg      <= '0;
            qidx_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            period_reg     <= period_next;
            counter_reg    <= counter_next;
            active_reg     <= active_next;
            pending_reg    <= pending_next;
            recv_reg       <= recv_next;
            pend_valid_reg <= pend_valid_next;
            held_reg       <= held_next;
            frame_reg      <= frame_next;
            fidx_reg       <= fidx_next;
            levels_reg     <= levels_next;
            motor_reg      <= motor_next;
            qidx_reg       <= qidx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tlast   = out_last_reg;

    // beats without a reply byte are always the single result of their item
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg[20]) |-> out_last_reg)
        else $error("non-reply beat not marked last");

    assert property (@(posedge clk) disable iff (!rst_n)
        fidx_reg <= FIDX_END)
        else $error("frame index past end of frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        !frame_reg |-> (fidx_reg == '0))
        else $error("frame index nonzero outside a frame");

    // a wrap with a committed update always consumes it
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.tick_step && pend_valid_reg && counter_reg >= period_reg) |=> !pend_valid_reg)
        else $error("committed update not applied at wrap");

endmodule

// ===== hw/rtl/serial_commanded_multichannel_pwm.sv =====
// Tick: after accept, the counter steps, the levels are compared, then the result is loaded
// into the output register once it is free (counter step, compare, emit). Command byte: the
// result is loaded once the output register is free; '?' gives 2*NUM_CHANNELS beats, one per
// cycle while m_tready is high. One item in flight: the next item is taken once the previous
// result is loaded into the output register.
// rst_n (async, active low) loads period 39999, widths 2000, all channels high, motor lines off.
module serial_commanded_multichannel_pwm
    import scmpwm_pkg::*;
#(
    parameter int NUM_CHANNELS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // rx_byte[7:0]
    input  logic        s_tuser,  // kind[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // channel_levels[15:0], motor_drive[19:16], tx_valid[20],
                                  // tx_byte[28:21], zero[31:29]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    scmpwm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    scmpwm_dp #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== tb/sv/tb_serial_commanded_multichannel_pwm.sv =====
`timescale 1ns / 1ps

module tb_serial_commanded_multichannel_pwm;
    import scmpwm_pkg::*;

    localparam int NCH = 16;
    localparam int FRAME_BYTES = 2 * NCH;

    typedef struct packed {
        logic [15:0] levels;
        logic [3:0]  motor;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        last;
    } pwm_beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // predicted block state
    logic [15:0] period_q;
    logic [15:0] tick_cnt;
    logic [15:0] active_w [NCH];
    logic [15:0] pending_w [NCH];
    logic [15:0] recv_w [NCH];
    logic        pending_ok;
    logic [7:0]  high_hold;
    logic        in_frame;
    logic [5:0]  frame_idx;
    logic [15:0] level_q;
    logic [3:0]  motor_q;

    pwm_beat_t expected_beats[$];
    int        mismatches;
    int        items_sent;
    bit        no_idle;

    serial_commanded_multichannel_pwm #(
        .NUM_CHANNELS(NCH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void queue_beat(logic valid, logic [7:0] data, logic fin);
        pwm_beat_t b;
        b.levels   = level_q;
        b.motor    = motor_q;
        b.tx_valid = valid;
        b.tx_byte  = valid ? data : 8'd0;
        b.last     = fin;
        expected_beats.push_back(b);
    endfunction

    function automatic void reset_pwm_state();
        period_q   = PERIOD_RESET;
        tick_cnt   = '0;
        pending_ok = 1'b0;
        high_hold  = '0;
        in_frame   = 1'b0;
        frame_idx  = '0;
        level_q    = '1;
        motor_q    = MOTOR_HALT;
        for (int i = 0; i < NCH; i++)
        begin
            active_w[i]  = RESET_WIDTH;
            pending_w[i] = RESET_WIDTH;
            recv_w[i]    = RESET_WIDTH;
        end
    endfunction

    function automatic void predict_pwm_item(logic kind, logic [7:0] data);
        if (kind == KIND_TICK)
        begin
            if (tick_cnt >= period_q)
            begin
                tick_cnt = '0;
                level_q  = '1;
                if (pending_ok)
                begin
                    for (int i = 0; i < NCH; i++)
                        active_w[i] = pending_w[i];
                    pending_ok = 1'b0;
                end
            end
            else
                tick_cnt = tick_cnt + 16'd1;
            for (int i = 0; i < NCH; i++)
                if (active_w[i] == tick_cnt)
                    level_q[i] = 1'b0;
            queue_beat(1'b0, 8'd0, 1'b1);
        end
        else if (in_frame)
        begin
            if (frame_idx < FRAME_BYTES)
            begin
                if (!frame_idx[0])
                    high_hold = data;
                else
                    recv_w[frame_idx[4:1]] = {high_hold, data};
                frame_idx = frame_idx + 6'd1;
            end
            else
            begin
                in_frame  = 1'b0;
                frame_idx = '0;
                if (data == CHAR_COMMIT)
                begin
                    for (int i = 0; i < NCH; i++)
                        pending_w[i] = recv_w[i];
                    pending_ok = 1'b1;
                end
            end
            queue_beat(1'b0, 8'd0, 1'b1);
        end
        else
        begin
            case (data)
                CHAR_FRAME:
                begin
                    in_frame  = 1'b1;
                    frame_idx = '0;
                    queue_beat(1'b0, 8'd0, 1'b1);
                end
                CHAR_FWD:   begin motor_q = MOTOR_FWD;   queue_beat(1'b1, REPLY_BYTE, 1'b1); end
                CHAR_BACK:  begin motor_q = MOTOR_BACK;  queue_beat(1'b1, REPLY_BYTE, 1'b1); end
                CHAR_LEFT:  begin motor_q = MOTOR_LEFT;  queue_beat(1'b1, REPLY_BYTE, 1'b1); end
                CHAR_RIGHT: begin motor_q = MOTOR_RIGHT; queue_beat(1'b1, REPLY_BYTE, 1'b1); end
                CHAR_HALT:  begin motor_q = MOTOR_HALT;  queue_beat(1'b1, REPLY_BYTE, 1'b1); end
                CHAR_QUERY:
                begin
                    for (int i = 0; i < NCH; i++)
                    begin
                        queue_beat(1'b1, recv_w[i][15:8], 1'b0);
                        queue_beat(1'b1, recv_w[i][7:0], i == NCH - 1);
                    end
                end
                default:
                    queue_beat(1'b0, 8'd0, 1'b1);
            endcase
        end
    endfunction

    // output beat checker
    always @(posedge clk)
    begin : check_beat
        pwm_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: tdata=%h tlast=%b", m_tdata, m_tlast);
            end
            else
            begin
                want = expected_beats.pop_front();
                if (m_tdata[15:0] !== want.levels || m_tdata[19:16] !== want.motor ||
                    m_tdata[20] !== want.tx_valid || m_tdata[28:21] !== want.tx_byte ||
                    m_tdata[31:29] !== 3'b000 || m_tlast !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"beat mismatch: exp levels=%h motor=%h txv=%b tx=%h last=%b,",
                                  " got levels=%h motor=%h txv=%b tx=%h pad=%b last=%b"},
                                 want.levels, want.motor, want.tx_valid, want.tx_byte,
                                 want.last, m_tdata[15:0], m_tdata[19:16], m_tdata[20],
                                 m_tdata[28:21], m_tdata[31:29], m_tlast);
                end
            end
        end
    end

    // downstream backpressure
    always @(negedge clk)
        m_tready = no_idle ? 1'b1 : ($urandom_range(0, 99) >= 10);

    task automatic send_item(input logic kind, input logic [7:0] data);
        while (!no_idle && $urandom_range(0, 99) < 10)
            @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = data;
        do @(posedge clk); while (!s_tready);
        predict_pwm_item(kind, data);
        items_sent++;
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic send_tick();
        send_item(KIND_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_period(input logic [15:0] value);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        period_q = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // 'M', width bytes with stray ticks, then ';' or a bad terminator
    task automatic send_frame(input bit good_end);
        int         top;
        logic [15:0] w;
        logic [7:0]  term;
        send_item(KIND_BYTE, CHAR_FRAME);
        top = int'(period_q) + 2;
        if (top > 65535)
            top = 65535;
        for (int i = 0; i < NCH; i++)
        begin
            w = ($urandom_range(0, 99) < 75) ? 16'($urandom_range(0, top))
                                              : 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 99) < 10)
                send_tick();
            send_item(KIND_BYTE, w[15:8]);
            if ($urandom_range(0, 99) < 10)
                send_tick();
            send_item(KIND_BYTE, w[7:0]);
        end
        if (good_end)
            term = CHAR_COMMIT;
        else
        begin
            do term = 8'($urandom_range(0, 255)); while (term == CHAR_COMMIT);
        end
        send_item(KIND_BYTE, term);
    endtask

    task automatic test_commands();
        send_item(KIND_BYTE, CHAR_QUERY);
        send_item(KIND_BYTE, CHAR_FWD);
        send_item(KIND_BYTE, CHAR_BACK);
        send_item(KIND_BYTE, CHAR_LEFT);
        send_item(KIND_BYTE, CHAR_RIGHT);
        send_item(KIND_BYTE, CHAR_HALT);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_TICK, 8'hFF);
        send_item(KIND_TICK, 8'h00);
    endtask

    task automatic test_period_edges();
        write_period(16'd0);
        repeat (3) send_tick();
        write_period(16'd1);
        repeat (3) send_tick();
        write_period(16'hFFFF);
        repeat (2) send_tick();
        // counter left above a lowered period
        write_period(16'd20);
        repeat (8) send_tick();
        write_period(16'd3);
        repeat (2) send_tick();
    endtask

    task automatic test_random_traffic();
        logic [15:0] periods [10];
        logic [7:0]  motor_chars [5];
        int          stop_at;
        int          pick;
        motor_chars = '{CHAR_FWD, CHAR_BACK, CHAR_LEFT, CHAR_RIGHT, CHAR_HALT};
        periods = '{16'd0, 16'd1, 16'd3, 16'd12, 16'd25, 16'hFFFF,
                    16'($urandom_range(2, 60)), 16'($urandom_range(4, 40)),
                    16'($urandom_range(1, 65535)), 16'd9};
        for (int p = 0; p < 10; p++)
        begin
            write_period(periods[p]);
            no_idle = (p == 4);
            stop_at = items_sent + 48;
            while (items_sent < stop_at)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    repeat ($urandom_range(1, 12)) send_tick();
                else if (pick < 65)
                    send_frame($urandom_range(0, 99) < 85);
                else if (pick < 75)
                    send_item(KIND_BYTE, motor_chars[$urandom_range(0, 4)]);
                else if (pick < 83)
                    send_item(KIND_BYTE, CHAR_QUERY);
                else
                    send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 99) < 3)
                    wait_drained();
            end
            no_idle = 1'b0;
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = KIND_TICK;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        mismatches = 0;
        items_sent = 0;
        no_idle    = 1'b0;
        reset_pwm_state();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_commands();
        test_period_edges();
        test_random_traffic();

        wait_drained();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/scmpwm_pkg.sv
hw/rtl/scmpwm_ctrl.sv
hw/rtl/scmpwm_dp.sv
hw/rtl/serial_commanded_multichannel_pwm.sv
tb/sv/tb_serial_commanded_multichannel_pwm.sv
